// ===== hw/rtl/pstc_pkg.sv =====
`timescale 1ns / 1ps
package pstc_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_NEW  = 2'd1;
  localparam logic [1:0] STATUS_DROP = 2'd2;

  typedef struct packed {
    logic [31:0] source_addr;
    logic [15:0] packet_length;
    logic [31:0] now_seconds;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
  } res_t;

  typedef struct packed {
    logic [31:0] packets;
    logic [47:0] bytes;
  } tot_t;

  typedef struct packed {
    logic capture;
    logic used;
    logic upd;
    logic create;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/per_source_traffic_counter_table.sv =====
`timescale 1ns / 1ps
// The input is registered on transfer; the update state then loads the result register.
// A new packet is taken only after the last one is done; all cells compare during the
// transfer cycle, then the update state updates the chosen cell and loads the result.
// A stalled result holds the update cycle until the result register can be reloaded.
// Reset (rst, synchronous): clears the fill count, sets window_seconds to 1 and
// empties the result register; entry contents are left as they are.
module per_source_traffic_counter_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           pkt_valid,
  output logic           pkt_stall,
  input  pstc_pkg::pkt_t pkt,
  output logic           res_valid,
  input  logic           res_stall,
  output pstc_pkg::res_t res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    window_seconds
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  localparam int unsigned N = pstc_pkg::TABLE_ENTRIES;
  localparam int unsigned CW = pstc_pkg::CNT_W;

  state_t                 state;
  state_t                 state_next;
  logic [15:0]            window;
  logic [CW-1:0]          used;
  pstc_pkg::pkt_t         item;
  logic                   accept;
  logic                   go;
  logic                   any;
  logic                   room;
  logic [N:0]             found;
  logic [N-1:0]           pick;
  pstc_pkg::cell_ctl_t    ctl [N];
  pstc_pkg::tot_t         tot [N];
  pstc_pkg::tot_t         tot_all;
  logic [CW-1:0]          hit_idx;
  pstc_pkg::res_t         res_next;

  assign cfg_ready = 1'b1;
  assign accept    = pkt_valid && !pkt_stall;
  assign pkt_stall = (state != ST_IDLE);
  assign go        = (state == ST_UPD) && (!res_valid || !res_stall);
  assign any       = found[N];
  assign room      = (used != CW'(N));

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      window <= window_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= pkt;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_UPD;
      end
      ST_UPD: begin
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (go && !any && room) begin
        used <= used + CW'(1);
      end
    end
  end

  assign found[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      ctl[i].capture = accept;
      ctl[i].used    = (CW'(i) < used);
      ctl[i].create  = !any && room && (used == CW'(i));
      ctl[i].upd     = go && (any ? pick[i] : ctl[i].create);
    end

    pstc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[i]),
      .cmp_item  (pkt),
      .new_item  (item),
      .window    (window),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .pick      (pick[i]),
      .tot       (tot[i])
    );
  end

  always_comb begin
    tot_all = '0;
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      tot_all = tot_all | tot[i];
      if (pick[i]) hit_idx = hit_idx | CW'(i);
    end
  end

  always_comb begin
    res_next              = '0;
    res_next.packet_total = tot_all.packets;
    res_next.byte_total   = tot_all.bytes;
    if (any) begin
      res_next.status      = pstc_pkg::STATUS_HIT;
      res_next.entry_index = 6'(hit_idx);
    end else if (room) begin
      res_next.status      = pstc_pkg::STATUS_NEW;
      res_next.entry_index = 6'(used);
    end else begin
      res_next.status = pstc_pkg::STATUS_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= res_next;
    end
  end

endmodule

// ===== hw/rtl/pstc_cell.sv =====
`timescale 1ns / 1ps
module pstc_cell (
  input  logic               clk,
  input  logic               rst,
  input  pstc_pkg::cell_ctl_t ctl,
  input  pstc_pkg::pkt_t     cmp_item,
  input  pstc_pkg::pkt_t     new_item,
  input  logic [15:0]        window,
  input  logic               found_in,
  output logic               found_out,
  output logic               pick,
  output pstc_pkg::tot_t     tot
);

  logic [31:0] addr;
  logic [31:0] start;
  logic [31:0] packets;
  logic [47:0] bytes;
  logic        hit;
  logic [31:0] age;
  logic [31:0] pkt_base;
  logic [47:0] byte_base;
  logic [31:0] packets_next;
  logic [47:0] bytes_next;
  logic [48:0] byte_sum;

  assign age = cmp_item.now_seconds - start;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.capture) begin
      hit <= ctl.used && (addr == cmp_item.source_addr) && (age < {16'd0, window});
    end
  end

  // lowest match wins: pass the claim down the chain
  assign pick      = hit & ~found_in;
  assign found_out = hit | found_in;

  always_comb begin
    pkt_base     = ctl.create ? 32'd0 : packets;
    byte_base    = ctl.create ? 48'd0 : bytes;
    packets_next = (pkt_base == 32'hFFFF_FFFF) ? pkt_base : pkt_base + 32'd1;
    byte_sum     = {1'b0, byte_base} + {33'd0, new_item.packet_length};
    bytes_next   = byte_sum[48] ? 48'hFFFF_FFFF_FFFF : byte_sum[47:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      packets <= packets_next;
      bytes   <= bytes_next;
      if (ctl.create) begin
        addr  <= new_item.source_addr;
        start <= new_item.now_seconds;
      end
    end
  end

  assign tot.packets = ctl.upd ? packets_next : 32'd0;
  assign tot.bytes   = ctl.upd ? bytes_next : 48'd0;

endmodule

// ===== hw/rtl/pstc_checker.sv =====
`timescale 1ns / 1ps
module pstc_checker (
  input logic           clk,
  input logic           rst,
  input logic           pkt_valid,
  input logic           pkt_stall,
  input logic           res_valid,
  input logic           res_stall,
  input pstc_pkg::res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_stall |=> pkt_stall)
    else $error("second transfer taken while busy");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == pstc_pkg::STATUS_DROP |->
      res.entry_index == 6'd0 && res.packet_total == 32'd0 && res.byte_total == 48'd0)
    else $error("dropped packet reports totals");

  a_new_first: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == pstc_pkg::STATUS_NEW |->
      res.packet_total == 32'd1 && res.byte_total[47:16] == 32'd0)
    else $error("new entry does not start at one packet");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == pstc_pkg::STATUS_HIT |-> res.packet_total != 32'd0)
    else $error("updated entry has zero packets");

endmodule

bind per_source_traffic_counter_table pstc_checker u_pstc_checker (.*);
